[hdl/efx_pkg.sv]
`timescale 1ns / 1ps
package efx_pkg;

  localparam int ORDER_LIMIT = 16;
  localparam int MAX_WINDOW  = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int ORD_W   = 5;
  localparam int WIN_W   = 13;
  localparam int VAL_W   = 35;
  localparam int COND_W  = 43;
  localparam int SUM_W   = 44;
  localparam int IDX_W   = 4;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int CFGI_W  = 2;

  localparam logic [WIN_W-1:0] COUNT_MAX = 13'd8191;

  // register indexes of the configuration port
  localparam logic [CFGI_W-1:0] CFG_ORDER   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_WINDOW  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_EXC_THR = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_ORD_THR = 2'd3;

  // effective configuration, limits already applied
  typedef struct packed {
    logic [ORD_W-1:0] n;
    logic [WIN_W-1:0] w;
    logic [VAL_W-1:0] exc_thr;
    logic [VAL_W-1:0] ord_thr;
  } efx_cfg_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic [ORDER_LIMIT-1:0][SAMPLE_BITS-1:0] hist;
    logic acc;
    logic last;
    logic err;
  } efx_cmd_t;

endpackage

[hdl/excitation_order_test_unit.sv]
`timescale 1ns / 1ps
// Persistence-of-excitation test over a record of Q1.15 samples. The front
// takes one sample per cycle into a two-entry queue while room is left; the
// back then takes one sample at a time and runs order*order products for it
// through one shared multiply-accumulate over the 256-entry correlation
// memory. A sample marked last adds the evaluation: order*order entries,
// each scaled by the window in a shift-subtract divider, one more division
// for the condition number and one per interpolated eigenvalue, then order
// results, one per eigenvalue index, each held in the output register until
// taken. A short run, a zero order or a zero window gives a single error
// result. The sums start cleared after reset and after every run.
module excitation_order_test_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [efx_pkg::CFGI_W-1:0]        cfg_index,
  input  logic [efx_pkg::VAL_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [efx_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [efx_pkg::IDX_W-1:0]         eigen_index,
  output logic [efx_pkg::VAL_W-1:0]         eigen_value,
  output logic [efx_pkg::VAL_W-1:0]         lower_bound,
  output logic [efx_pkg::COND_W-1:0]        cond_ratio,
  output logic                              is_excited,
  output logic [efx_pkg::ORD_W-1:0]         excitation_order,
  output logic                              last_result
);

  logic [efx_pkg::ORD_W-1:0] order;
  logic [efx_pkg::WIN_W-1:0] window;
  logic [efx_pkg::VAL_W-1:0] exc_thr;
  logic [efx_pkg::VAL_W-1:0] ord_thr;
  efx_pkg::efx_cfg_t         cfg;

  logic              push_valid;
  logic              push_ready;
  efx_pkg::efx_cmd_t push_cmd;
  logic              pop_valid;
  logic              pop_ready;
  efx_pkg::efx_cmd_t pop_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order   <= 5'd4;
      window  <= 13'd256;
      exc_thr <= 35'd11;
      ord_thr <= 35'd1074;
    end else if (cfg_write) begin
      case (cfg_index)
        efx_pkg::CFG_ORDER:   order   <= cfg_data[efx_pkg::ORD_W-1:0];
        efx_pkg::CFG_WINDOW:  window  <= cfg_data[efx_pkg::WIN_W-1:0];
        efx_pkg::CFG_EXC_THR: exc_thr <= cfg_data;
        efx_pkg::CFG_ORD_THR: ord_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit order and window
  always_comb begin
    cfg.n = (order > 5'(efx_pkg::ORDER_LIMIT)) ? 5'(efx_pkg::ORDER_LIMIT) : order;
    cfg.w = (window > 13'(efx_pkg::MAX_WINDOW)) ? 13'(efx_pkg::MAX_WINDOW) : window;
    cfg.exc_thr = exc_thr;
    cfg.ord_thr = ord_thr;
  end

  efx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .last       (last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  efx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  efx_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd_valid        (pop_valid),
    .cmd_ready        (pop_ready),
    .cmd              (pop_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .eigen_index      (eigen_index),
    .eigen_value      (eigen_value),
    .lower_bound      (lower_bound),
    .cond_ratio       (cond_ratio),
    .is_excited       (is_excited),
    .excitation_order (excitation_order),
    .last_result      (last_result)
  );

endmodule

[hdl/efx_div.sv]
`timescale 1ns / 1ps
module efx_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [efx_pkg::SUM_W-1:0]    dividend,
  input  logic [efx_pkg::VAL_W-1:0]    divisor,
  output logic                         done,
  output logic [efx_pkg::SUM_W-1:0]    quotient
);

  logic [efx_pkg::VAL_W-1:0] rem;
  logic [efx_pkg::VAL_W-1:0] dvs;
  logic [5:0]                cnt;
  logic                      busy;
  logic [efx_pkg::VAL_W:0]   rem_sh;
  logic [efx_pkg::VAL_W:0]   rem_sub;

  // one restoring step
  always_comb begin
    rem_sh  = {rem, quotient[efx_pkg::SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
        cnt      <= 6'(efx_pkg::SUM_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem      <= rem_sub[efx_pkg::VAL_W-1:0];
          quotient <= {quotient[efx_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[efx_pkg::VAL_W-1:0];
          quotient <= {quotient[efx_pkg::SUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/efx_queue.sv]
`timescale 1ns / 1ps
module efx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  efx_pkg::efx_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output efx_pkg::efx_cmd_t pop_cmd
);

  efx_pkg::efx_cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    push_ready = (fill != 2'd2);
    pop_valid  = (fill != 2'd0);
    pop_cmd    = slots[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  // two-entry fifo
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr        <= ~wr_ptr;
      end
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (!do_push && do_pop) fill <= fill - 2'd1;
    end
  end

endmodule

[hdl/efx_front.sv]
`timescale 1ns / 1ps
module efx_front (
  input  logic                              clk,
  input  logic                              rst,
  input  efx_pkg::efx_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [efx_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                              last,
  output logic                              push_valid,
  input  logic                              push_ready,
  output efx_pkg::efx_cmd_t                 push_cmd
);

  logic [efx_pkg::ORDER_LIMIT-1:0][efx_pkg::SAMPLE_BITS-1:0] hist;
  logic [efx_pkg::WIN_W-1:0] count;
  logic [efx_pkg::WIN_W-1:0] count_inc;
  logic [efx_pkg::WIN_W:0]   need;
  logic                      accept;

  // classify the item against the run position
  always_comb begin
    count_inc = (count == efx_pkg::COUNT_MAX) ? count : count + 13'd1;
    need      = {9'd0, cfg.n} + {1'b0, cfg.w};
    in_ready  = push_ready;
    push_valid = in_valid;
    accept    = in_valid && push_ready;
    push_cmd.hist = hist;
    push_cmd.last = last;
    push_cmd.acc  = (cfg.n != '0) && ({1'b0, count} >= {9'd0, cfg.n}) &&
                    ({1'b0, count} < need);
    push_cmd.err  = (cfg.n == '0) || (cfg.w == '0) || ({1'b0, count_inc} < need);
  end

  // lag history and sample count
  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      count <= '0;
    end else if (accept) begin
      if (last) begin
        hist  <= '0;
        count <= '0;
      end else begin
        hist  <= {hist[efx_pkg::ORDER_LIMIT-2:0], sample};
        count <= count_inc;
      end
    end
  end

endmodule

[hdl/efx_back.sv]
`timescale 1ns / 1ps
module efx_back (
  input  logic                             clk,
  input  logic                             rst,
  input  efx_pkg::efx_cfg_t                cfg,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  efx_pkg::efx_cmd_t                cmd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             status,
  output logic [efx_pkg::IDX_W-1:0]        eigen_index,
  output logic [efx_pkg::VAL_W-1:0]        eigen_value,
  output logic [efx_pkg::VAL_W-1:0]        lower_bound,
  output logic [efx_pkg::COND_W-1:0]       cond_ratio,
  output logic                             is_excited,
  output logic [efx_pkg::ORD_W-1:0]        excitation_order,
  output logic                             last_result
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_FIN, S_RD, S_DVS, S_DVW,
    S_FLOOR, S_CDS, S_CDW, S_EVK, S_EVW, S_OUT
  } state_t;

  localparam int DW = efx_pkg::VAL_W + 1;

  state_t state;

  // correlation sums memory with per-entry valid bits
  logic signed [efx_pkg::SUM_W-1:0] sums [1 << efx_pkg::ADDR_W];
  logic [(1 << efx_pkg::ADDR_W)-1:0] vbits;
  logic signed [efx_pkg::SUM_W-1:0] rdata;
  logic                             rvld;
  logic [efx_pkg::ADDR_W-1:0]       rd_addr;
  logic                             clear_all;

  logic [efx_pkg::ORDER_LIMIT-1:0][efx_pkg::SAMPLE_BITS-1:0] hist_r;
  logic last_r;
  logic err_r;

  // multiply-accumulate pipeline
  logic [efx_pkg::IDX_W-1:0]        mi;
  logic [efx_pkg::IDX_W-1:0]        mj;
  logic                             p1_vld;
  logic [efx_pkg::ADDR_W-1:0]       p1_addr;
  logic signed [efx_pkg::PROD_W-1:0] p1_prod;
  logic signed [efx_pkg::PROD_W-1:0] prod;
  logic [efx_pkg::IDX_W-1:0]        nm1;

  // evaluation
  logic [efx_pkg::IDX_W-1:0] ei;
  logic [efx_pkg::IDX_W-1:0] ej;
  logic                      neg_r;
  logic [efx_pkg::VAL_W-1:0] row;
  logic [efx_pkg::VAL_W-1:0] off;
  logic [DW-1:0]             diag;
  logic [efx_pkg::VAL_W-1:0] upper;
  logic [DW-1:0]             lower;
  logic [efx_pkg::VAL_W-1:0] lower_f;
  logic                      lead;
  logic [efx_pkg::ORD_W-1:0] exo_cnt;
  logic [efx_pkg::ORD_W-1:0] exo;
  logic [efx_pkg::COND_W-1:0] cond;
  logic [efx_pkg::IDX_W-1:0] k;
  logic                      kneg;

  logic signed [efx_pkg::SUM_W-1:0] val;
  logic [efx_pkg::SUM_W-1:0]        mag;
  logic [efx_pkg::VAL_W-1:0]        q35;
  logic [efx_pkg::VAL_W-1:0]        row_new;
  logic [efx_pkg::VAL_W-1:0]        off_new;
  logic [DW-1:0]                    diag_new;
  logic [DW-1:0]                    li;
  logic [DW-1:0]                    diff;
  logic signed [40:0]               kd;
  logic [40:0]                      kmag;
  logic [efx_pkg::VAL_W-1:0]        lfl;
  logic [efx_pkg::VAL_W-1:0]        ev_div;

  logic                      div_start;
  logic [efx_pkg::SUM_W-1:0] div_dividend;
  logic [efx_pkg::VAL_W-1:0] div_divisor;
  logic                      div_done;
  logic [efx_pkg::SUM_W-1:0] div_q;

  efx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // datapath selects
  always_comb begin
    nm1       = efx_pkg::IDX_W'(cfg.n - 5'd1);
    cmd_ready = (state == S_IDLE);
    rd_addr   = (state == S_MAC) ? {mi, mj} : {ei, ej};
    prod      = $signed(hist_r[mi]) * $signed(hist_r[mj]);
    clear_all = (state == S_OUT) && out_ready && last_result;

    val = rvld ? rdata : '0;
    mag = val[efx_pkg::SUM_W-1] ? efx_pkg::SUM_W'(-val) : efx_pkg::SUM_W'(val);

    q35      = div_q[efx_pkg::VAL_W-1:0];
    row_new  = row + q35;
    off_new  = (ej == ei) ? off : off + q35;
    diag_new = (ej == ei) ? (neg_r ? DW'(-{1'b0, q35}) : {1'b0, q35}) : diag;
    li       = diag_new - {1'b0, off_new};

    lfl  = (lower[DW-1] || (lower == '0)) ? efx_pkg::VAL_W'(1) : lower[efx_pkg::VAL_W-1:0];
    diff = {1'b0, upper} - {1'b0, lower_f};
    kd   = $signed({1'b0, k}) * $signed(diff);
    kmag = kd[40] ? 41'(-kd) : 41'(kd);
    ev_div = kneg ? lower_f - q35 : lower_f + q35;

    div_start    = (state == S_DVS) || (state == S_CDS) ||
                   ((state == S_EVK) && (k != '0) && (k != nm1));
    div_dividend = mag;
    div_divisor  = {22'd0, cfg.w};
    case (state)
      S_CDS: begin
        div_dividend = {1'b0, upper, 8'd0};
        div_divisor  = lower_f;
      end
      S_EVK: begin
        div_dividend = {3'd0, kmag};
        div_divisor  = {31'd0, nm1};
      end
      default: begin
        div_dividend = mag;
        div_divisor  = {22'd0, cfg.w};
      end
    endcase
  end

  // sums memory: registered read, pipelined write
  always_ff @(posedge clk) begin
    rdata <= sums[rd_addr];
    if (p1_vld) sums[p1_addr] <= (rvld ? rdata : '0) + efx_pkg::SUM_W'(p1_prod);
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vbits <= '0;
    end else if (p1_vld) begin
      vbits[p1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rvld    <= vbits[rd_addr];
    p1_addr <= rd_addr;
    p1_prod <= prod;
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p1_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_vld <= (state == S_MAC);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            hist_r <= cmd.hist;
            last_r <= cmd.last;
            err_r  <= cmd.err;
            mi     <= '0;
            mj     <= '0;
            if (cmd.acc) state <= S_MAC;
            else if (cmd.last) state <= S_FIN;
          end
        end
        S_MAC: begin
          if (mj == nm1) begin
            mj <= '0;
            if (mi == nm1) state <= S_DRAIN;
            else mi <= mi + 4'd1;
          end else begin
            mj <= mj + 4'd1;
          end
        end
        S_DRAIN: begin
          state <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (err_r) begin
            status           <= 1'b1;
            eigen_index      <= '0;
            eigen_value      <= '0;
            lower_bound      <= '0;
            cond_ratio       <= '0;
            is_excited       <= 1'b0;
            excitation_order <= '0;
            last_result      <= 1'b1;
            out_valid        <= 1'b1;
            state            <= S_OUT;
          end else begin
            ei      <= '0;
            ej      <= '0;
            row     <= '0;
            off     <= '0;
            upper   <= '0;
            lead    <= 1'b1;
            exo_cnt <= '0;
            state   <= S_RD;
          end
        end
        S_RD: begin
          state <= S_DVS;
        end
        S_DVS: begin
          neg_r <= val[efx_pkg::SUM_W-1];
          state <= S_DVW;
        end
        S_DVW: begin
          if (div_done) begin
            diag <= diag_new;
            if (ej == nm1) begin
              row <= '0;
              off <= '0;
              ej  <= '0;
              if (row_new > upper) upper <= row_new;
              if ((ei == '0) || ($signed(li) < $signed(lower))) lower <= li;
              if (lead) begin
                if (diag_new[DW-1] || ($signed(diag_new) <= $signed({1'b0, cfg.ord_thr})))
                  lead <= 1'b0;
                else
                  exo_cnt <= exo_cnt + 5'd1;
              end
              if (ei == nm1) state <= S_FLOOR;
              else begin
                ei    <= ei + 4'd1;
                state <= S_RD;
              end
            end else begin
              row   <= row_new;
              off   <= off_new;
              ej    <= ej + 4'd1;
              state <= S_RD;
            end
          end
        end
        S_FLOOR: begin
          lower_f <= lfl;
          state   <= S_CDS;
        end
        S_CDS: begin
          state <= S_CDW;
        end
        S_CDW: begin
          if (div_done) begin
            cond  <= div_q[efx_pkg::COND_W-1:0];
            exo   <= (lower_f > cfg.ord_thr) ? cfg.n : exo_cnt;
            k     <= '0;
            state <= S_EVK;
          end
        end
        S_EVK: begin
          status           <= 1'b0;
          eigen_index      <= k;
          lower_bound      <= lower_f;
          cond_ratio       <= cond;
          is_excited       <= (lower_f > cfg.exc_thr);
          excitation_order <= exo;
          last_result      <= (k == nm1);
          if (k == '0) begin
            eigen_value <= upper;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else if (k == nm1) begin
            eigen_value <= lower_f;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else begin
            kneg  <= kd[40];
            state <= S_EVW;
          end
        end
        S_EVW: begin
          if (div_done) begin
            eigen_value <= ev_div;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) state <= S_IDLE;
            else begin
              k     <= k + 4'd1;
              state <= S_EVK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
